[rtl/som_pkg.sv]
// Shared types and constants for the self-organizing map training core.
// Holds the fixed-point constants, the 2^-x step table and the control bundles.
// No dependencies.
package som_pkg;

   localparam int NODE_COUNT  = 256;
   localparam int NODE_W      = 8;
   localparam int SIDE_W      = 5;
   localparam int COORD_W     = 4;
   localparam int WEIGHT_BITS = 16;
   localparam int WORD_W      = 3 * WEIGHT_BITS;
   localparam int ITER_W      = 16;
   localparam int RATE_W      = 16;
   localparam int DIST_W      = 35;
   localparam int R2_W        = 40;

   localparam int DIV_NUM_W = 60;
   localparam int DIV_DEN_W = 41;
   localparam int DIV_Q_W   = 20;
   localparam int EXP_X_W   = 34;
   localparam int EXP_V_W   = 31;

   localparam logic [SIDE_W-1:0] SIDE_MIN = 5'd2;
   localparam logic [SIDE_W-1:0] SIDE_MAX = 5'd16;

   localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
   localparam logic [EXP_V_W-1:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [EXP_V_W-1:0] HALF_Q30  = 31'h2000_0000;

   localparam logic [1:0] CSR_LATTICE_SIDE     = 2'd0;
   localparam logic [1:0] CSR_TOTAL_ITERATIONS = 2'd1;
   localparam logic [1:0] CSR_BEGIN_RATE       = 2'd2;

   localparam logic MODE_LOAD = 1'b1;

   typedef struct packed {
      logic latch;
      logic load_write;
      logic refuse;
      logic log_start;
      logic ydiv_start;
      logic yexp_start;
      logic r2_set;
      logic node_clear;
      logic node_advance;
      logic search_issue;
      logic upd_read;
      logic zdiv_start;
      logic zexp_start;
      logic gain_set;
      logic upd_write;
      logic qdiv_start;
      logic qexp_start;
      logic rate_set;
   } dp_cmd_type;

   typedef struct packed {
      logic mode_load;
      logic steps_zero;
      logic log_done;
      logic div_done;
      logic exp_done;
      logic node_last;
      logic pipe_empty;
      logic near;
   } dp_status_type;

   function automatic logic [29:0] root_step(input logic [3:0] idx);
      logic [29:0] r;
      case (idx)
         4'd0:  r = 30'd759250125;
         4'd1:  r = 30'd902905651;
         4'd2:  r = 30'd984625594;
         4'd3:  r = 30'd1028218693;
         4'd4:  r = 30'd1050733751;
         4'd5:  r = 30'd1062175491;
         4'd6:  r = 30'd1067942999;
         4'd7:  r = 30'd1070838486;
         4'd8:  r = 30'd1072289173;
         4'd9:  r = 30'd1073015252;
         4'd10: r = 30'd1073378477;
         4'd11: r = 30'd1073560135;
         4'd12: r = 30'd1073650976;
         4'd13: r = 30'd1073696399;
         4'd14: r = 30'd1073719111;
         4'd15: r = 30'd1073730468;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

[rtl/som_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on som_pkg for operand widths.
module som_div import som_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_Q_W-1:0]   quo,
   output logic                 done
);

   logic                 run_ff;
   logic [4:0]           cnt_ff;
   logic [DIV_NUM_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] ds_ff;
   logic [DIV_Q_W-1:0]   quo_ff;
   logic                 done_ff;
   logic                 ge;

   assign ge = rem_ff >= ds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_Q_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         ds_ff  <= {den, {(DIV_Q_W - 1){1'b0}}};
         quo_ff <= '0;
      end else if (run_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - ds_ff;
         end
         quo_ff <= {quo_ff[DIV_Q_W-2:0], ge};
         ds_ff  <= ds_ff >> 1;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

[rtl/som_exp.sv]
// Power-of-two unit: 2^-x for Q.16 x, result Q1.30, one fraction bit per cycle.
// Depends on som_pkg for the step table.
module som_exp import som_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [EXP_X_W-1:0] x,
   output logic [EXP_V_W-1:0] value,
   output logic               done
);

   logic               run_ff;
   logic [4:0]         cnt_ff;
   logic               done_ff;
   logic [15:0]        frac_ff;
   logic               big_ff;
   logic [4:0]         shift_ff;
   logic [EXP_V_W-1:0] v_ff;
   logic [EXP_V_W-1:0] value_ff;
   logic [60:0]        prod;
   logic [60:0]        rounded;

   assign prod    = 61'(v_ff) * 61'(root_step(cnt_ff[3:0]));
   assign rounded = prod + 61'(HALF_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            if (cnt_ff == 5'd16) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         frac_ff  <= x[15:0];
         big_ff   <= x[EXP_X_W-1:16] > 18'd30;
         shift_ff <= x[20:16];
         v_ff     <= ONE_Q30;
      end else if (run_ff) begin
         if (cnt_ff == 5'd16) begin
            value_ff <= big_ff ? '0 : (v_ff >> shift_ff);
         end else begin
            if (frac_ff[15]) begin
               v_ff <= rounded[60:30];
            end
            frac_ff <= {frac_ff[14:0], 1'b0};
         end
      end
   end

   assign value = value_ff;
   assign done  = done_ff;

endmodule

[rtl/som_dp.sv]
// Datapath: configuration, node weight memory, search and update arithmetic.
// Depends on som_pkg, som_div and som_exp.
module som_dp import som_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic                   req_mode,
   input  logic [NODE_W-1:0]      req_node_index,
   input  logic signed [15:0]     req_comp_a,
   input  logic signed [15:0]     req_comp_b,
   input  logic signed [15:0]     req_comp_c,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   output logic                   rsp_accepted,
   output logic [NODE_W-1:0]      rsp_winner_index,
   output logic [ITER_W-1:0]      rsp_steps_done,
   output logic                   rsp_finished
);

   logic [SIDE_W-1:0] side_ff;
   logic [ITER_W-1:0] total_ff;
   logic [RATE_W-1:0] begin_ff;
   logic [ITER_W-1:0] steps_left_ff;
   logic [RATE_W-1:0] rate_ff;

   logic                    mode_ff;
   logic [NODE_W-1:0]       idx_ff;
   logic signed [15:0]      s_a_ff, s_b_ff, s_c_ff;
   logic                    accepted_ff;
   logic [NODE_W-1:0]       winner_ff;

   logic [WORD_W-1:0] mem [NODE_COUNT];
   logic [WORD_W-1:0] rd_data_ff;

   logic [NODE_W-1:0]  node_ff;
   logic [COORD_W-1:0] row_ff, col_ff;

   logic [SIDE_W-1:0]  sat_side;
   logic [9:0]         count_prod;
   logic [8:0]         node_count;
   logic [ITER_W-1:0]  t_val;

   logic [2:0]  log_int;
   logic [20:0] m_init;
   logic [2:0]  n_ff;
   logic [16:0] m_ff;
   logic [15:0] lfrac_ff;
   logic [3:0]  log_cnt_ff;
   logic        log_run_ff;
   logic        log_done_ff;
   logic [33:0] m_sq;

   logic [R2_W-1:0] r2q_ff;

   logic                p1_v_ff, p2_v_ff;
   logic [NODE_W-1:0]   p1_idx_ff, p2_idx_ff;
   logic [COORD_W-1:0]  p1_row_ff, p1_col_ff, p2_row_ff, p2_col_ff;
   logic [32:0]         sq_a_ff, sq_b_ff, sq_c_ff;
   logic [DIST_W-1:0]   dist_sum;
   logic [DIST_W-1:0]   best_d_ff;
   logic [NODE_W-1:0]   best_ff;
   logic [COORD_W-1:0]  best_row_ff, best_col_ff;

   logic [COORD_W-1:0] dr, dc;
   logic [8:0]         d2;
   logic [8:0]         d2_ff;
   logic               near_ff;
   logic [RATE_W-1:0]  gain_ff;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_Q_W-1:0]   div_quo;
   logic                 div_done;
   logic                 exp_start;
   logic [EXP_X_W-1:0]   exp_x;
   logic [EXP_V_W-1:0]   exp_val;
   logic                 exp_done;

   logic [46:0] gain_sum;
   logic [46:0] rate_sum;
   logic [WORD_W-1:0] upd_word;

   function automatic logic [32:0] square_diff(input logic signed [15:0] w,
                                               input logic signed [15:0] s);
      logic signed [16:0] diff;
      logic signed [33:0] sq;
      diff = 17'(w) - 17'(s);
      sq   = diff * diff;
      return sq[32:0];
   endfunction

   function automatic logic [15:0] move_weight(input logic signed [15:0] w,
                                               input logic signed [15:0] s,
                                               input logic [RATE_W-1:0] gain);
      logic signed [16:0] diff;
      logic [16:0]        mag_a;
      logic [33:0]        prod;
      logic [16:0]        mag;
      logic signed [16:0] res;
      diff  = 17'(s) - 17'(w);
      mag_a = diff[16] ? 17'(-diff) : 17'(diff);
      prod  = 34'(mag_a) * 34'(gain) + 34'd32768;
      mag   = prod[32:16];
      res   = diff[16] ? 17'(w) - $signed(mag) : 17'(w) + $signed(mag);
      return res[15:0];
   endfunction

   assign sat_side   = (side_ff < SIDE_MIN) ? SIDE_MIN :
                       (side_ff > SIDE_MAX) ? SIDE_MAX : side_ff;
   assign count_prod = 10'(sat_side) * 10'(sat_side);
   assign node_count = count_prod[8:0];
   assign t_val      = total_ff - steps_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff       <= 5'd8;
         total_ff      <= 16'd1000;
         begin_ff      <= 16'd6554;
         steps_left_ff <= 16'd1000;
         rate_ff       <= 16'd6554;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LATTICE_SIDE: begin
                  side_ff <= csr_data[SIDE_W-1:0];
               end
               CSR_TOTAL_ITERATIONS: begin
                  total_ff      <= csr_data;
                  steps_left_ff <= csr_data;
               end
               CSR_BEGIN_RATE: begin
                  begin_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
         if (cmd.rate_set) begin
            rate_ff       <= rate_sum[45:30];
            steps_left_ff <= steps_left_ff - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= 1'b0;
         winner_ff   <= '0;
      end else begin
         if (cmd.load_write) begin
            accepted_ff <= 1'b1;
            winner_ff   <= '0;
         end else if (cmd.refuse) begin
            accepted_ff <= 1'b0;
            winner_ff   <= '0;
         end else if (cmd.rate_set) begin
            accepted_ff <= 1'b1;
            winner_ff   <= best_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode;
         idx_ff  <= req_node_index;
         s_a_ff  <= req_comp_a;
         s_b_ff  <= req_comp_b;
         s_c_ff  <= req_comp_c;
      end
   end

   assign upd_word = {move_weight(rd_data_ff[47:32], s_c_ff, gain_ff),
                      move_weight(rd_data_ff[31:16], s_b_ff, gain_ff),
                      move_weight(rd_data_ff[15:0],  s_a_ff, gain_ff)};

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         mem[idx_ff] <= {s_c_ff, s_b_ff, s_a_ff};
      end else if (cmd.upd_write) begin
         mem[node_ff] <= upd_word;
      end
      if (cmd.search_issue || cmd.upd_read) begin
         rd_data_ff <= mem[node_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (cmd.node_clear) begin
         node_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (cmd.node_advance) begin
         node_ff <= node_ff + 8'd1;
         if ({1'b0, col_ff} == sat_side - 5'd1) begin
            col_ff <= '0;
            row_ff <= row_ff + 4'd1;
         end else begin
            col_ff <= col_ff + 4'd1;
         end
      end
   end

   assign log_int = sat_side[4] ? 3'd4 : sat_side[3] ? 3'd3 : sat_side[2] ? 3'd2 : 3'd1;
   assign m_init  = {sat_side, 16'd0} >> log_int;
   assign m_sq    = 34'(m_ff) * 34'(m_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         log_run_ff  <= 1'b0;
         log_cnt_ff  <= '0;
         log_done_ff <= 1'b0;
      end else begin
         log_done_ff <= 1'b0;
         if (cmd.log_start) begin
            log_run_ff <= 1'b1;
            log_cnt_ff <= '0;
         end else if (log_run_ff) begin
            log_cnt_ff <= log_cnt_ff + 4'd1;
            if (log_cnt_ff == 4'd15) begin
               log_run_ff  <= 1'b0;
               log_done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.log_start) begin
         n_ff     <= log_int;
         m_ff     <= m_init[16:0];
         lfrac_ff <= '0;
      end else if (log_run_ff) begin
         if (m_sq[33]) begin
            m_ff <= m_sq[33:17];
         end else begin
            m_ff <= m_sq[32:16];
         end
         lfrac_ff <= {lfrac_ff[14:0], m_sq[33]};
      end
   end

   assign div_start = cmd.ydiv_start | cmd.zdiv_start | cmd.qdiv_start;

   always_comb begin
      div_num = 60'(t_val);
      div_den = 41'(steps_left_ff);
      if (cmd.ydiv_start) begin
         div_num = 60'({35'(19'({n_ff, lfrac_ff})) * 35'(t_val), 1'b0});
         div_den = 41'(total_ff);
      end else if (cmd.zdiv_start) begin
         div_num = 60'({26'(LOG2E_Q16) * 26'(d2_ff), 30'd0});
         div_den = {r2q_ff, 1'b0};
      end
   end

   assign exp_start = cmd.yexp_start | cmd.zexp_start | cmd.qexp_start;
   assign exp_x     = cmd.qexp_start ? 34'(33'(div_quo[15:0]) * 33'(LOG2E_Q16))
                                     : 34'(div_quo);

   som_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   som_exp u_exp (
      .clock (clock),
      .reset (reset),
      .start (exp_start),
      .x     (exp_x),
      .value (exp_val),
      .done  (exp_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.r2_set) begin
         r2q_ff <= R2_W'(node_count) * R2_W'(exp_val);
      end
   end

   assign dist_sum = DIST_W'(sq_a_ff) + DIST_W'(sq_b_ff) + DIST_W'(sq_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= cmd.search_issue;
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_issue) begin
         p1_idx_ff <= node_ff;
         p1_row_ff <= row_ff;
         p1_col_ff <= col_ff;
      end
      if (p1_v_ff) begin
         p2_idx_ff <= p1_idx_ff;
         p2_row_ff <= p1_row_ff;
         p2_col_ff <= p1_col_ff;
         sq_a_ff   <= square_diff(rd_data_ff[15:0],  s_a_ff);
         sq_b_ff   <= square_diff(rd_data_ff[31:16], s_b_ff);
         sq_c_ff   <= square_diff(rd_data_ff[47:32], s_c_ff);
      end
      if (p2_v_ff && (p2_idx_ff == '0 || dist_sum < best_d_ff)) begin
         best_d_ff   <= dist_sum;
         best_ff     <= p2_idx_ff;
         best_row_ff <= p2_row_ff;
         best_col_ff <= p2_col_ff;
      end
   end

   assign dr = (row_ff > best_row_ff) ? row_ff - best_row_ff : best_row_ff - row_ff;
   assign dc = (col_ff > best_col_ff) ? col_ff - best_col_ff : best_col_ff - col_ff;
   assign d2 = 9'(8'(dr) * 8'(dr)) + 9'(8'(dc) * 8'(dc));

   assign gain_sum = 47'(rate_ff) * 47'(exp_val) + 47'(HALF_Q30);
   assign rate_sum = 47'(begin_ff) * 47'(exp_val) + 47'(HALF_Q30);

   always_ff @(posedge clock) begin
      if (cmd.upd_read) begin
         d2_ff   <= d2;
         near_ff <= R2_W'({d2, 30'd0}) < r2q_ff;
      end
      if (cmd.gain_set) begin
         gain_ff <= gain_sum[45:30];
      end
   end

   assign status.mode_load  = mode_ff == MODE_LOAD;
   assign status.steps_zero = steps_left_ff == '0;
   assign status.log_done   = log_done_ff;
   assign status.div_done   = div_done;
   assign status.exp_done   = exp_done;
   assign status.node_last  = {1'b0, node_ff} == node_count - 9'd1;
   assign status.pipe_empty = !p1_v_ff && !p2_v_ff;
   assign status.near       = near_ff;

   assign rsp_accepted     = accepted_ff;
   assign rsp_winner_index = winner_ff;
   assign rsp_steps_done   = t_val;
   assign rsp_finished     = steps_left_ff == '0;

endmodule

[rtl/som_ctrl.sv]
// Controller state machine that sequences loads and training steps.
// Depends on som_pkg for the command and status bundles.
module som_ctrl import som_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          rsp_valid
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_DECIDE = 5'd1;
   localparam logic [4:0] ST_LOAD   = 5'd2;
   localparam logic [4:0] ST_LOG    = 5'd3;
   localparam logic [4:0] ST_YDIV   = 5'd4;
   localparam logic [4:0] ST_YEXP   = 5'd5;
   localparam logic [4:0] ST_SEARCH = 5'd6;
   localparam logic [4:0] ST_DRAIN  = 5'd7;
   localparam logic [4:0] ST_UREAD  = 5'd8;
   localparam logic [4:0] ST_UCHECK = 5'd9;
   localparam logic [4:0] ST_ZDIV   = 5'd10;
   localparam logic [4:0] ST_ZEXP   = 5'd11;
   localparam logic [4:0] ST_UWRITE = 5'd12;
   localparam logic [4:0] ST_QDIV   = 5'd13;
   localparam logic [4:0] ST_QEXP   = 5'd14;
   localparam logic [4:0] ST_RESP   = 5'd15;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.mode_load) begin
               state_in = ST_LOAD;
            end else if (status.steps_zero) begin
               cmd.refuse = 1'b1;
               state_in   = ST_RESP;
            end else begin
               cmd.log_start = 1'b1;
               state_in      = ST_LOG;
            end
         end
         ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = ST_RESP;
         end
         ST_LOG: begin
            if (status.log_done) begin
               cmd.ydiv_start = 1'b1;
               state_in       = ST_YDIV;
            end
         end
         ST_YDIV: begin
            if (status.div_done) begin
               cmd.yexp_start = 1'b1;
               state_in       = ST_YEXP;
            end
         end
         ST_YEXP: begin
            if (status.exp_done) begin
               cmd.r2_set     = 1'b1;
               cmd.node_clear = 1'b1;
               state_in       = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_issue = 1'b1;
            cmd.node_advance = 1'b1;
            if (status.node_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               cmd.node_clear = 1'b1;
               state_in       = ST_UREAD;
            end
         end
         ST_UREAD: begin
            cmd.upd_read = 1'b1;
            state_in     = ST_UCHECK;
         end
         ST_UCHECK: begin
            if (status.near) begin
               cmd.zdiv_start = 1'b1;
               state_in       = ST_ZDIV;
            end else if (status.node_last) begin
               cmd.qdiv_start = 1'b1;
               state_in       = ST_QDIV;
            end else begin
               cmd.node_advance = 1'b1;
               state_in         = ST_UREAD;
            end
         end
         ST_ZDIV: begin
            if (status.div_done) begin
               cmd.zexp_start = 1'b1;
               state_in       = ST_ZEXP;
            end
         end
         ST_ZEXP: begin
            if (status.exp_done) begin
               cmd.gain_set = 1'b1;
               state_in     = ST_UWRITE;
            end
         end
         ST_UWRITE: begin
            cmd.upd_write = 1'b1;
            if (status.node_last) begin
               cmd.qdiv_start = 1'b1;
               state_in       = ST_QDIV;
            end else begin
               cmd.node_advance = 1'b1;
               state_in         = ST_UREAD;
            end
         end
         ST_QDIV: begin
            if (status.div_done) begin
               cmd.qexp_start = 1'b1;
               state_in       = ST_QEXP;
            end
         end
         ST_QEXP: begin
            if (status.exp_done) begin
               cmd.rate_set = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_RESP;

endmodule

[rtl/som_training_step_core.sv]
// Self-organizing map training core, one item at a time.
// A load passes through the decide and load states; a refused train item skips the load state.
// A train item's length grows with the node count N and the neighborhood node count M,
// set by the node sweeps over the single weight memory and the bit-serial divider and 2^-x unit.
// The result strobe lasts one cycle and cannot be held off; busy falls the cycle after.
// Synchronous reset restores the register defaults; weights are undefined until loaded.
module som_training_step_core import som_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic [NODE_W-1:0]     req_node_index,
   input  logic signed [15:0]    req_comp_a,
   input  logic signed [15:0]    req_comp_b,
   input  logic signed [15:0]    req_comp_c,
   output logic                  rsp_valid,
   output logic                  rsp_accepted,
   output logic [NODE_W-1:0]     rsp_winner_index,
   output logic [ITER_W-1:0]     rsp_steps_done,
   output logic                  rsp_finished,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   som_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   som_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_node_index   (req_node_index),
      .req_comp_a       (req_comp_a),
      .req_comp_b       (req_comp_b),
      .req_comp_c       (req_comp_c),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_accepted     (rsp_accepted),
      .rsp_winner_index (rsp_winner_index),
      .rsp_steps_done   (rsp_steps_done),
      .rsp_finished     (rsp_finished)
   );

endmodule

[sim/tb_top.sv]
// Bench for som_training_step_core: loads all nodes, a directed table, random load/train phases.
// Results are checked against typed table rows or a fixed-point predictor of the map in this file.
// Depends on rtl/som_pkg.sv and rtl/som_training_step_core.sv.
module tb_top;
   import som_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              accepted;
      logic [NODE_W-1:0] winner;
      logic [ITER_W-1:0] steps_done;
      logic              finished;
   } som_result_type;

   typedef struct packed {
      logic              is_csr;
      logic [1:0]        csr_idx;
      logic [15:0]       csr_val;
      logic              mode;
      logic [7:0]        node;
      logic [15:0]       a;
      logic [15:0]       b;
      logic [15:0]       c;
      logic              typed;
      som_result_type    want;
   } som_row_type;

   localparam longint unsigned HALF30 = 64'd536870912;
   localparam longint unsigned ONE30  = 64'd1073741824;
   localparam longint unsigned LOG2E  = 64'd94548;
   localparam longint unsigned CYCLE_LIMIT = 64'd20000000;

   longint unsigned root_tab [16] = '{
      759250125, 902905651, 984625594, 1028218693,
      1050733751, 1062175491, 1067942999, 1070838486,
      1072289173, 1073015252, 1073378477, 1073560135,
      1073650976, 1073696399, 1073719111, 1073730468};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = 1'b0;
   logic [NODE_W-1:0] req_node_index = '0;
   logic signed [15:0] req_comp_a = '0, req_comp_b = '0, req_comp_c = '0;
   logic rsp_valid, rsp_accepted, rsp_finished;
   logic [NODE_W-1:0] rsp_winner_index;
   logic [ITER_W-1:0] rsp_steps_done;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   som_training_step_core u_top (.*);

   // Predictor state.
   longint map_wgt [NODE_COUNT][3];
   logic [SIDE_W-1:0] map_side = 5'd8;
   longint unsigned map_total = 1000, map_begin = 6554, map_left = 1000, map_rate = 6554;

   som_result_type pending_results [$];
   int fails = 0;
   longint unsigned cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("som_training_step_core regression: fail");
         $finish;
      end
   end

   function automatic longint unsigned exp2_neg_q(longint unsigned x);
      longint unsigned k, v;
      k = x >> 16;
      v = ONE30;
      if (k > 30) return 0;
      for (int j = 0; j < 16; j++)
         if ((x >> (15 - j)) & 1) v = (v * root_tab[j] + HALF30) >> 30;
      return v >> k;
   endfunction

   function automatic longint unsigned log2_q(longint unsigned side);
      int n;
      longint unsigned m, l;
      n = 0;
      while ((side >> (n + 1)) != 0) n++;
      m = side << (16 - n);
      l = longint'(n) << 16;
      for (int b = 15; b >= 0; b--) begin
         m = (m * m) >> 16;
         if (m >= 131072) begin
            m = m >> 1;
            l = l | (64'd1 << b);
         end
      end
      return l;
   endfunction

   function automatic int train_map(longint s [3]);
      longint unsigned side, n, t, y, r2q, best_d, d, a, d2, z, gain, br, bc, r, col, dr, dc, q;
      longint diff, mag;
      int best;
      side = map_side;
      if (side < 2) side = 2;
      if (side > 16) side = 16;
      n = side * side;
      t = map_total - map_left;
      best = 0;
      best_d = 0;
      for (int i = 0; i < n; i++) begin
         d = 0;
         for (int c = 0; c < 3; c++) begin
            diff = map_wgt[i][c] - s[c];
            a = diff < 0 ? -diff : diff;
            d += a * a;
         end
         if (i == 0 || d < best_d) begin
            best_d = d;
            best = i;
         end
      end
      y = (2 * log2_q(side) * t) / map_total;
      r2q = n * exp2_neg_q(y);
      br = best / side;
      bc = best % side;
      for (int i = 0; i < n; i++) begin
         r = i / side;
         col = i % side;
         dr = r > br ? r - br : br - r;
         dc = col > bc ? col - bc : bc - col;
         d2 = dr * dr + dc * dc;
         if ((d2 << 30) < r2q) begin
            z = ((LOG2E * d2) << 30) / (2 * r2q);
            gain = (map_rate * exp2_neg_q(z) + HALF30) >> 30;
            for (int c = 0; c < 3; c++) begin
               diff = s[c] - map_wgt[i][c];
               a = diff < 0 ? -diff : diff;
               mag = longint'((a * gain + 32768) >> 16);
               map_wgt[i][c] += diff < 0 ? -mag : mag;
            end
         end
      end
      q = t / map_left;
      map_rate = (map_begin * exp2_neg_q(q * LOG2E) + HALF30) >> 30;
      map_left = map_left - 1;
      return best;
   endfunction

   function automatic som_result_type predict_item(logic mode, logic [7:0] node,
                                                   logic [15:0] a, logic [15:0] b,
                                                   logic [15:0] c);
      som_result_type res;
      longint s [3];
      s[0] = longint'($signed(a));
      s[1] = longint'($signed(b));
      s[2] = longint'($signed(c));
      res = '0;
      if (mode == MODE_LOAD) begin
         for (int k = 0; k < 3; k++) map_wgt[node][k] = s[k];
         res.accepted = 1'b1;
      end else if (map_left != 0) begin
         res.winner = NODE_W'(train_map(s));
         res.accepted = 1'b1;
      end
      res.steps_done = ITER_W'(map_total - map_left);
      res.finished = map_left == 0;
      return res;
   endfunction

   always @(posedge clock) begin
      som_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no expectation waiting");
            fails++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_accepted !== exp_r.accepted) begin
               $error("accepted: expected %0d actual %0d", exp_r.accepted, rsp_accepted);
               fails++;
            end
            if (rsp_winner_index !== exp_r.winner) begin
               $error("winner_index: expected %0d actual %0d", exp_r.winner, rsp_winner_index);
               fails++;
            end
            if (rsp_steps_done !== exp_r.steps_done) begin
               $error("steps_done: expected %0d actual %0d", exp_r.steps_done, rsp_steps_done);
               fails++;
            end
            if (rsp_finished !== exp_r.finished) begin
               $error("finished: expected %0d actual %0d", exp_r.finished, rsp_finished);
               fails++;
            end
         end
      end
   end

   task automatic send_item(int gap, logic mode, logic [7:0] node, logic [15:0] a,
                            logic [15:0] b, logic [15:0] c, logic typed,
                            som_result_type want);
      som_result_type pred;
      if (gap > 0) begin
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_node_index <= node;
      req_comp_a <= a;
      req_comp_b <= b;
      req_comp_c <= c;
      do @(posedge clock); while (busy);
      pred = predict_item(mode, node, a, b, c);
      pending_results.push_back(typed ? want : pred);
   endtask

   task automatic drain;
      @(negedge clock) start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_LATTICE_SIDE: map_side = val[SIDE_W-1:0];
         CSR_TOTAL_ITERATIONS: begin
            map_total = val;
            map_left = val;
         end
         default: map_begin = val;
      endcase
      @(negedge clock) csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] pick_comp();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_gap();
      return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
   endfunction

   som_row_type rows [];
   logic [SIDE_W-1:0] phase_side [12] = '{2, 3, 0, 4, 31, 1, 5, 16, 2, 3, 6, 2};

   initial begin
      int count;
      logic [15:0] tot, rate;
      som_result_type none;
      none = '0;
      rows = '{
         '{0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, '0},
         '{0, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, '0},
         '{0, 0, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0, '0},
         '{0, 0, 0, 1, 0, 16'h7FFF, 16'h8000, 16'h0000, 1, '{1, 0, 3, 0}},
         '{0, 0, 0, 1, 255, 16'h8000, 16'h7FFF, 16'hFFFF, 1, '{1, 0, 3, 0}},
         '{1, CSR_LATTICE_SIDE, 16'd2, 0, 0, 0, 0, 0, 0, '0},
         '{1, CSR_TOTAL_ITERATIONS, 16'd2, 0, 0, 0, 0, 0, 0, '0},
         '{1, CSR_BEGIN_RATE, 16'hFFFF, 0, 0, 0, 0, 0, 0, '0},
         '{0, 0, 0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, '{1, 0, 0, 0}},
         '{0, 0, 0, 1, 1, 16'h0000, 16'h0000, 16'h0000, 1, '{1, 0, 0, 0}},
         '{0, 0, 0, 1, 2, 16'h0000, 16'h0000, 16'h0000, 1, '{1, 0, 0, 0}},
         '{0, 0, 0, 1, 3, 16'h0000, 16'h0000, 16'h0000, 1, '{1, 0, 0, 0}},
         '{0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 1, '{1, 0, 1, 0}},
         '{0, 0, 0, 0, 0, 16'h4000, 16'hC000, 16'h1234, 0, '0},
         '{0, 0, 0, 0, 0, 16'h0100, 16'h0100, 16'h0100, 1, '{0, 0, 2, 1}},
         '{0, 0, 0, 1, 3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, '{1, 0, 2, 1}},
         '{1, CSR_LATTICE_SIDE, 16'd0, 0, 0, 0, 0, 0, 0, '0},
         '{1, CSR_TOTAL_ITERATIONS, 16'd1, 0, 0, 0, 0, 0, 0, '0},
         '{1, CSR_BEGIN_RATE, 16'd0, 0, 0, 0, 0, 0, 0, '0},
         '{0, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 0, '0},
         '{0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 1, '{0, 0, 1, 1}}
      };
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (int i = 0; i < NODE_COUNT; i++)
         send_item(pick_gap(), MODE_LOAD, 8'(i), pick_comp(), pick_comp(), pick_comp(), 0, none);

      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            drain();
            write_csr(rows[i].csr_idx, rows[i].csr_val);
         end else begin
            send_item(pick_gap(), rows[i].mode, rows[i].node, rows[i].a, rows[i].b,
                      rows[i].c, rows[i].typed, rows[i].want);
         end
      end

      for (int ph = 0; ph < 12; ph++) begin
         drain();
         tot = 16'($urandom_range(1, 200));
         if (ph == 3) tot = 16'hFFFF;
         if (ph == 5) tot = 16'd0;
         if (ph == 6) tot = 16'd1;
         rate = 16'($urandom);
         if (ph == 1) rate = 16'd0;
         if (ph == 2) rate = 16'hFFFF;
         write_csr(CSR_LATTICE_SIDE, 16'(phase_side[ph]));
         write_csr(CSR_TOTAL_ITERATIONS, tot);
         write_csr(CSR_BEGIN_RATE, rate);
         count = (phase_side[ph] > 6) ? 8 : 85;
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 35)
               send_item((k % 20 < 4) ? 0 : pick_gap(), MODE_LOAD, 8'($urandom),
                         pick_comp(), pick_comp(), pick_comp(), 0, none);
            else
               send_item((k % 20 < 4) ? 0 : pick_gap(), 1'b0, 8'($urandom),
                         pick_comp(), pick_comp(), pick_comp(), 0, none);
         end
      end

      drain();
      if (fails == 0)
         $display("som_training_step_core regression: pass");
      else
         $display("som_training_step_core regression: fail");
      $finish;
   end

endmodule
